// ===== sv/two_body_gravity_derivative_core_defines.svh =====
// assertion macros shared by the checker
`ifndef TWO_BODY_GRAVITY_DERIVATIVE_CORE_DEFINES_SVH
`define TWO_BODY_GRAVITY_DERIVATIVE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GBD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GBD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gbd_pkg.sv =====
package gbd_pkg;

  localparam int POS_W  = 32;
  localparam int VEL_W  = 32;
  localparam int ACC_W  = 32;
  localparam int GM_W   = 53;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;
  localparam int DEN_W  = SQ_W + ROOT_W;
  localparam int ACC_FRAC_BITS_DEF = 24;

  localparam logic [GM_W-1:0] GRAV_RESET = 53'd398600441800000;

  // stage counts of each unit
  localparam int FRONT_STAGES = 3;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int MUL_STAGES   = 2;
  localparam int DIV_STAGES   = ACC_W + 2;
  localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + MUL_STAGES + DIV_STAGES;

  // per-item data that rides along the pipeline
  typedef struct packed {
    logic [POS_W-1:0] ux;
    logic [POS_W-1:0] uy;
    logic             px_pos;
    logic             py_pos;
    logic             zero;
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
  } gbd_side_t;

endpackage

// ===== sv/gbd_in_if.sv =====
interface gbd_in_if import gbd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// ===== sv/gbd_out_if.sv =====
interface gbd_out_if import gbd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] dpos_x;
  logic signed [VEL_W-1:0] dpos_y;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic                    range_flag;

  modport source (output valid, dpos_x, dpos_y, acc_x, acc_y, range_flag, input ready);
  modport sink   (input valid, dpos_x, dpos_y, acc_x, acc_y, range_flag, output ready);
endinterface

// ===== sv/gbd_front.sv =====
module gbd_front import gbd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [VEL_W-1:0] vel_x,
  input  logic signed [VEL_W-1:0] vel_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SQ_W-1:0]         s,
  output gbd_side_t               side
);

  logic              vld_r [FRONT_STAGES];
  logic              rdy   [FRONT_STAGES+1];
  gbd_side_t         side0_r, side1_r, side2_r, side0_nxt;
  logic [SQ_W-1:0]   sqx_r, sqy_r, s_r;

  // per-stage ready: a stage takes new data when empty or draining
  assign rdy[FRONT_STAGES] = out_ready;
  for (genvar i = 0; i < FRONT_STAGES; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[FRONT_STAGES-1];

  // magnitudes and signs
  always_comb begin
    side0_nxt        = '0;
    side0_nxt.ux     = pos_x[POS_W-1] ? (~pos_x + 1'b1) : pos_x;
    side0_nxt.uy     = pos_y[POS_W-1] ? (~pos_y + 1'b1) : pos_y;
    side0_nxt.px_pos = !pos_x[POS_W-1] && (pos_x != '0);
    side0_nxt.py_pos = !pos_y[POS_W-1] && (pos_y != '0);
    side0_nxt.zero   = (pos_x == '0) && (pos_y == '0);
    side0_nxt.vel_x  = vel_x;
    side0_nxt.vel_y  = vel_y;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRONT_STAGES; i++) vld_r[i] <= 1'b0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
    end
  end

  // payload: abs, squares, sum of squares
  always_ff @(posedge clk) begin
    if (rdy[0]) side0_r <= side0_nxt;
    if (rdy[1]) begin
      side1_r <= side0_r;
      sqx_r   <= side0_r.ux * side0_r.ux;
      sqy_r   <= side0_r.uy * side0_r.uy;
    end
    if (rdy[2]) begin
      side2_r <= side1_r;
      s_r     <= sqx_r + sqy_r;
    end
  end

  assign s    = s_r;
  assign side = side2_r;

endmodule

// ===== sv/gbd_sqrt.sv =====
module gbd_sqrt import gbd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SQ_W-1:0]   s_in,
  input  gbd_side_t         side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SQ_W-1:0]   s_out,
  output logic [ROOT_W-1:0] root,
  output gbd_side_t         side_out
);

  logic            vld_r  [SQRT_STAGES];
  logic            rdy    [SQRT_STAGES+1];
  logic [SQ_W-1:0] rem_r  [SQRT_STAGES];
  logic [SQ_W-1:0] res_r  [SQRT_STAGES];
  logic [SQ_W-1:0] s_r    [SQRT_STAGES];
  gbd_side_t       side_r [SQRT_STAGES];

  assign rdy[SQRT_STAGES] = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[SQRT_STAGES-1];

  // one result bit per stage, restoring digit recurrence
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_st
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2*i);
    logic            v_in;
    logic [SQ_W-1:0] rem_in, res_in, s_in_i, t, rem_nxt, res_nxt;
    gbd_side_t       sd_in;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = s_in;
      assign res_in = '0;
      assign s_in_i = s_in;
      assign sd_in  = side_in;
    end else begin : g_next
      assign v_in   = vld_r[i-1];
      assign rem_in = rem_r[i-1];
      assign res_in = res_r[i-1];
      assign s_in_i = s_r[i-1];
      assign sd_in  = side_r[i-1];
    end

    assign rdy[i] = !vld_r[i] || rdy[i+1];

    always_comb begin
      t = res_in + BIT;
      if (rem_in >= t) begin
        rem_nxt = rem_in - t;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        rem_r[i]  <= rem_nxt;
        res_r[i]  <= res_nxt;
        s_r[i]    <= s_in_i;
        side_r[i] <= sd_in;
      end
    end
  end

  assign s_out    = s_r[SQRT_STAGES-1];
  assign root     = res_r[SQRT_STAGES-1][ROOT_W-1:0];
  assign side_out = side_r[SQRT_STAGES-1];

endmodule

// ===== sv/gbd_mul.sv =====
module gbd_mul import gbd_pkg::*; #(
  parameter int ACC_FRAC_BITS = ACC_FRAC_BITS_DEF,
  parameter int NUM_W         = GM_W + POS_W + ACC_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [GM_W-1:0]   grav_param,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SQ_W-1:0]   s,
  input  logic [ROOT_W-1:0] root,
  input  gbd_side_t         side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DEN_W-1:0]  den,
  output logic [NUM_W-1:0]  num_x,
  output logic [NUM_W-1:0]  num_y,
  output gbd_side_t         side_out
);

  localparam int LO_W  = 32;
  localparam int GHI_W = GM_W - LO_W;
  localparam int PL_W  = LO_W + POS_W;
  localparam int PH_W  = GHI_W + POS_W;

  logic                    vld0_r, vld1_r, rdy0, rdy1;
  logic [SQ_W-1:0]         ps_lo_r, ps_hi_r;
  logic [PL_W-1:0]         gx_lo_r, gy_lo_r;
  logic [PH_W-1:0]         gx_hi_r, gy_hi_r;
  gbd_side_t               side0_r, side1_r;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [NUM_W-1:0]        nx_r, ny_r, nx_nxt, ny_nxt;

  assign rdy1      = !vld1_r || out_ready;
  assign rdy0      = !vld0_r || rdy1;
  assign in_ready  = rdy0;
  assign out_valid = vld1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
    end else begin
      if (rdy0) vld0_r <= in_valid;
      if (rdy1) vld1_r <= vld0_r;
    end
  end

  // partial products, each 32 bits wide or less per operand
  always_ff @(posedge clk) begin
    if (rdy0) begin
      ps_lo_r <= s[LO_W-1:0] * root;
      ps_hi_r <= s[SQ_W-1:LO_W] * root;
      gx_lo_r <= grav_param[LO_W-1:0] * side_in.ux;
      gx_hi_r <= grav_param[GM_W-1:LO_W] * side_in.ux;
      gy_lo_r <= grav_param[LO_W-1:0] * side_in.uy;
      gy_hi_r <= grav_param[GM_W-1:LO_W] * side_in.uy;
      side0_r <= side_in;
    end
  end

  // recombine; numerator is scaled by the fraction bits
  always_comb begin
    den_nxt = (DEN_W'(ps_hi_r) << LO_W) + DEN_W'(ps_lo_r);
    nx_nxt  = (NUM_W'(gx_hi_r) << (LO_W + ACC_FRAC_BITS))
            + (NUM_W'(gx_lo_r) << ACC_FRAC_BITS);
    ny_nxt  = (NUM_W'(gy_hi_r) << (LO_W + ACC_FRAC_BITS))
            + (NUM_W'(gy_lo_r) << ACC_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      den_r   <= den_nxt;
      nx_r    <= nx_nxt;
      ny_r    <= ny_nxt;
      side1_r <= side0_r;
    end
  end

  assign den      = den_r;
  assign num_x    = nx_r;
  assign num_y    = ny_r;
  assign side_out = side1_r;

endmodule

// ===== sv/gbd_div.sv =====
module gbd_div import gbd_pkg::*; #(
  parameter int ACC_FRAC_BITS = ACC_FRAC_BITS_DEF,
  parameter int NUM_W         = GM_W + POS_W + ACC_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DEN_W-1:0] den,
  input  logic [NUM_W-1:0] num_x,
  input  logic [NUM_W-1:0] num_y,
  input  gbd_side_t        side_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VEL_W-1:0] dpos_x,
  output logic [VEL_W-1:0] dpos_y,
  output logic [ACC_W-1:0] acc_x,
  output logic [ACC_W-1:0] acc_y,
  output logic             range_flag
);

  localparam int CW = (NUM_W > DEN_W + ACC_W) ? NUM_W : DEN_W + ACC_W;
  localparam int QS = DIV_STAGES - 1;  // overflow stage plus one per quotient bit

  logic             vld_r  [DIV_STAGES];
  logic             rdy    [DIV_STAGES+1];
  logic [CW-1:0]    rem_r  [QS][2];
  logic [ACC_W-1:0] q_r    [QS][2];
  logic             ov_r   [QS][2];
  logic [DEN_W-1:0] den_r  [QS];
  gbd_side_t        side_r [QS];
  logic [ACC_W-1:0] acc_x_r, acc_y_r, acc_x_nxt, acc_y_nxt;
  logic [VEL_W-1:0] dpx_r, dpy_r;
  logic             flag_r, flag_nxt;

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[DIV_STAGES-1];

  // overflow check, then one quotient bit per stage for both lanes
  for (genvar i = 0; i < QS; i++) begin : g_st
    logic             v_in;
    logic [CW-1:0]    rin [2];
    logic [ACC_W-1:0] qin [2];
    logic             oin [2];
    logic [DEN_W-1:0] d_in;
    gbd_side_t        sd_in;
    logic [CW-1:0]    rem_nxt [2];
    logic [ACC_W-1:0] q_nxt   [2];
    logic             ov_nxt  [2];

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rin[0] = CW'(num_x);
      assign rin[1] = CW'(num_y);
      assign qin[0] = '0;
      assign qin[1] = '0;
      assign oin[0] = 1'b0;
      assign oin[1] = 1'b0;
      assign d_in   = den;
      assign sd_in  = side_in;
    end else begin : g_next
      assign v_in   = vld_r[i-1];
      assign rin[0] = rem_r[i-1][0];
      assign rin[1] = rem_r[i-1][1];
      assign qin[0] = q_r[i-1][0];
      assign qin[1] = q_r[i-1][1];
      assign oin[0] = ov_r[i-1][0];
      assign oin[1] = ov_r[i-1][1];
      assign d_in   = den_r[i-1];
      assign sd_in  = side_r[i-1];
    end

    assign rdy[i] = !vld_r[i] || rdy[i+1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
      if (i == 0) begin : g_ovf
        assign ov_nxt[l]  = rin[l] >= (CW'(d_in) << ACC_W);
        assign rem_nxt[l] = rin[l];
        assign q_nxt[l]   = qin[l];
      end else begin : g_bit
        localparam int J = ACC_W - i;
        logic [CW-1:0] dsh;
        logic          ge;
        assign dsh        = CW'(d_in) << J;
        assign ge         = rin[l] >= dsh;
        assign rem_nxt[l] = ge ? (rin[l] - dsh) : rin[l];
        assign q_nxt[l]   = qin[l] | (ge ? (ACC_W'(1) << J) : '0);
        assign ov_nxt[l]  = oin[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        rem_r[i][0] <= rem_nxt[0];
        rem_r[i][1] <= rem_nxt[1];
        q_r[i][0]   <= q_nxt[0];
        q_r[i][1]   <= q_nxt[1];
        ov_r[i][0]  <= ov_nxt[0];
        ov_r[i][1]  <= ov_nxt[1];
        den_r[i]    <= d_in;
        side_r[i]   <= sd_in;
      end
    end
  end

  // saturate, apply sign, zero-radius override
  always_comb begin
    logic [ACC_W:0]   mag  [2];
    logic [ACC_W-1:0] lim  [2];
    logic [ACC_W-1:0] magc [2];
    logic             sat  [2];
    logic             pos  [2];
    logic [ACC_W-1:0] acc  [2];
    pos[0] = side_r[QS-1].px_pos;
    pos[1] = side_r[QS-1].py_pos;
    for (int l = 0; l < 2; l++) begin
      lim[l]  = pos[l] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      mag[l]  = ov_r[QS-1][l] ? ({1'b0, lim[l]} + 1'b1) : {1'b0, q_r[QS-1][l]};
      sat[l]  = mag[l] > {1'b0, lim[l]};
      magc[l] = sat[l] ? lim[l] : mag[l][ACC_W-1:0];
      acc[l]  = pos[l] ? (~magc[l] + 1'b1) : magc[l];
    end
    if (side_r[QS-1].zero) begin
      acc_x_nxt = '0;
      acc_y_nxt = '0;
      flag_nxt  = 1'b1;
    end else begin
      acc_x_nxt = acc[0];
      acc_y_nxt = acc[1];
      flag_nxt  = sat[0] || sat[1];
    end
  end

  assign rdy[QS] = !vld_r[QS] || rdy[QS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[QS] <= 1'b0;
    end else if (rdy[QS]) begin
      vld_r[QS] <= vld_r[QS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[QS]) begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      flag_r  <= flag_nxt;
      dpx_r   <= side_r[QS-1].vel_x;
      dpy_r   <= side_r[QS-1].vel_y;
    end
  end

  assign dpos_x     = dpx_r;
  assign dpos_y     = dpy_r;
  assign acc_x      = acc_x_r;
  assign acc_y      = acc_y_r;
  assign range_flag = flag_r;

endmodule

// ===== sv/two_body_gravity_derivative_core.sv =====
// throughput: one item per cycle while the output is taken; every stage has
// its own valid and ready, so a stalled output only holds items back until
// the stages ahead fill
// the 32-stage square root and the 32 quotient stages set the depth
// reset: synchronous active-low rst_n empties the pipeline and loads grav_param
module two_body_gravity_derivative_core import gbd_pkg::*; #(
  parameter int ACC_FRAC_BITS = ACC_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  gbd_in_if.sink          in_ch,
  gbd_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [GM_W-1:0] cfg_wdata
);

  localparam int NUM_W = GM_W + POS_W + ACC_FRAC_BITS;

  logic [GM_W-1:0]   gm_r;
  logic              f_valid, f_ready, q_valid, q_ready, m_valid, m_ready;
  logic [SQ_W-1:0]   f_s, q_s;
  logic [ROOT_W-1:0] q_root;
  gbd_side_t         f_side, q_side, m_side;
  logic [DEN_W-1:0]  m_den;
  logic [NUM_W-1:0]  m_nx, m_ny;

  // gravitational parameter register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r <= GRAV_RESET;
    end else if (cfg_we) begin
      gm_r <= cfg_wdata;
    end
  end

  gbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .vel_x     (in_ch.vel_x),
    .vel_y     (in_ch.vel_y),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .s         (f_s),
    .side      (f_side)
  );

  gbd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .s_in      (f_s),
    .side_in   (f_side),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .s_out     (q_s),
    .root      (q_root),
    .side_out  (q_side)
  );

  gbd_mul #(
    .ACC_FRAC_BITS (ACC_FRAC_BITS),
    .NUM_W         (NUM_W)
  ) u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .grav_param (gm_r),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .s          (q_s),
    .root       (q_root),
    .side_in    (q_side),
    .out_valid  (m_valid),
    .out_ready  (m_ready),
    .den        (m_den),
    .num_x      (m_nx),
    .num_y      (m_ny),
    .side_out   (m_side)
  );

  gbd_div #(
    .ACC_FRAC_BITS (ACC_FRAC_BITS),
    .NUM_W         (NUM_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (m_valid),
    .in_ready   (m_ready),
    .den        (m_den),
    .num_x      (m_nx),
    .num_y      (m_ny),
    .side_in    (m_side),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .dpos_x     (out_ch.dpos_x),
    .dpos_y     (out_ch.dpos_y),
    .acc_x      (out_ch.acc_x),
    .acc_y      (out_ch.acc_y),
    .range_flag (out_ch.range_flag)
  );

endmodule

// ===== sv/gbd_chk.sv =====
`include "two_body_gravity_derivative_core_defines.svh"

module gbd_chk import gbd_pkg::*; #(
  parameter int DEPTH = PIPE_DEPTH
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VEL_W-1:0] dpos_x,
  input logic [VEL_W-1:0] dpos_y,
  input logic [ACC_W-1:0] acc_x,
  input logic [ACC_W-1:0] acc_y,
  input logic             range_flag
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items inside the pipeline
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) cnt_nxt = cnt_r + 1'b1;
    if (!in_acc && out_acc) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a result needs an item that went in before it
  `GBD_ASSERT_NOW(a_no_phantom, clk, rst_n, out_valid, cnt_r != '0, "result with no item in flight")

  // the pipeline never holds more items than it has stages
  `GBD_ASSERT_NOW(a_depth, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH), "more items in flight than stages")

  // a waiting result holds still
  `GBD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(acc_x) && $stable(acc_y) && $stable(dpos_x) && $stable(dpos_y) && $stable(range_flag), "stalled result changed")

endmodule

bind two_body_gravity_derivative_core gbd_chk u_gbd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .dpos_x     (out_ch.dpos_x),
  .dpos_y     (out_ch.dpos_y),
  .acc_x      (out_ch.acc_x),
  .acc_y      (out_ch.acc_y),
  .range_flag (out_ch.range_flag)
);

// ===== sim/tb_two_body_gravity_derivative_core.sv =====
module tb_two_body_gravity_derivative_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gbd_pkg::*;

  localparam int ACC_FRAC = 24;
  localparam int LATENCY = PIPE_DEPTH + 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [GM_W-1:0] GM_MAX = {GM_W{1'b1}};

  typedef struct packed {
    logic [31:0] dpos_x;
    logic [31:0] dpos_y;
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic        range_flag;
  } deriv_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [GM_W-1:0] cfg_wdata = '0;

  gbd_in_if  in_ch ();
  gbd_out_if out_ch ();

  two_body_gravity_derivative_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [GM_W-1:0] gm_model;
  deriv_t expected_q[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit idle_enable = 1'b1;
  int hold_off = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    out_ch.ready = 1'b0;
  end

  // integer square root, floor
  function automatic logic [63:0] isqrt(input logic [63:0] s);
    logic [63:0] res;
    logic [63:0] trial;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= s) res = trial;
    end
    return res;
  endfunction

  // one acceleration component, saturated
  function automatic logic [31:0] accel_comp(input logic signed [31:0] p,
                                             input logic [127:0] den,
                                             inout logic sat);
    logic [127:0] num;
    logic [127:0] mag;
    logic [63:0] up;
    logic [63:0] limit;
    if (p == 0) return '0;
    up = (p < 0) ? 64'(-64'(p)) : 64'(p);
    num = (128'(gm_model) * 128'(up)) << ACC_FRAC;
    mag = num / den;
    limit = (p > 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag > 128'(limit)) begin
      mag = 128'(limit);
      sat = 1'b1;
    end
    return (p > 0) ? 32'(-mag) : mag[31:0];
  endfunction

  // expected derivative of one state
  function automatic deriv_t derive_state(input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic [31:0] vx,
                                          input logic [31:0] vy);
    deriv_t d;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [63:0] s;
    logic [127:0] den;
    logic sat;
    ux = (px < 0) ? 64'(-64'(px)) : 64'(px);
    uy = (py < 0) ? 64'(-64'(py)) : 64'(py);
    s = ux * ux + uy * uy;
    sat = 1'b0;
    d.dpos_x = vx;
    d.dpos_y = vy;
    if (s == 0) begin
      d.acc_x = '0;
      d.acc_y = '0;
      sat = 1'b1;
    end else begin
      den = 128'(s) * 128'(isqrt(s));
      d.acc_x = accel_comp(px, den, sat);
      d.acc_y = accel_comp(py, den, sat);
    end
    d.range_flag = sat;
    return d;
  endfunction

  // send one item, with optional random gap first
  task automatic send_state(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] vx, input logic [31:0] vy);
    int gap;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.vel_x <= vx;
    in_ch.vel_y <= vy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(derive_state(px, py, vx, vy));
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_gm(input logic [GM_W-1:0] gm);
    drain_pipe();
    cfg_we <= 1'b1;
    cfg_wdata <= gm;
    @(posedge clk);
    cfg_we <= 1'b0;
    gm_model = gm;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20000)) - 10000);
      2: return 32'($signed($urandom_range(6_000_000, 50_000_000))
                   * ($urandom_range(0, 1) ? 1 : -1));
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 1_000_000)) - 500_000);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edges[6];
    edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd6_771_000};
    send_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 6; i++)
      send_state(edges[i], edges[(i + 2) % 6], $urandom, $urandom);
    send_state(32'h8000_0000, 32'h8000_0000, 0, 32'hFFFF_FFFF);
    send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_state(1, 0, 0, 0);
    send_state(0, 32'hFFFF_FFFF, 0, 0);
    send_state(32'd6_771_000, 32'hFF98_AF18, 32'd500_000_000, 32'hE223_3000);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_state(rand_pos(), rand_pos(), $urandom, $urandom);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 300;
    test_random(120);
  endtask

  task automatic test_config_sweep();
    write_gm(GM_MAX);
    test_directed();
    test_random(80);
    write_gm(53'd1);
    test_directed();
    test_random(80);
    write_gm(53'd4902800066000);
    test_random(80);
    write_gm(GRAV_RESET);
  endtask

  // output ready with random stall bursts and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_enable && out_ch.ready && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
    end else if (!out_ch.ready && idle_enable && $urandom_range(0, 3) != 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    deriv_t want;
    deriv_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.dpos_x, out_ch.dpos_y, out_ch.acc_x, out_ch.acc_y, out_ch.range_flag};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.dpos_x !== want.dpos_x)
          $display("%0t dpos_x exp %h got %h", $time, want.dpos_x, got.dpos_x);
        if (got.dpos_y !== want.dpos_y)
          $display("%0t dpos_y exp %h got %h", $time, want.dpos_y, got.dpos_y);
        if (got.acc_x !== want.acc_x)
          $display("%0t acc_x exp %h got %h", $time, want.acc_x, got.acc_x);
        if (got.acc_y !== want.acc_y)
          $display("%0t acc_y exp %h got %h", $time, want.acc_y, got.acc_y);
        if (got.range_flag !== want.range_flag)
          $display("%0t range_flag exp %b got %b", $time, want.range_flag, got.range_flag);
        if (got !== want) fail_count++;
      end
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    gm_model = GRAV_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    test_backpressure();
    test_config_sweep();
    idle_enable = 1'b0;
    test_random(80);
    drain_pipe();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/gbd_pkg.sv
sv/gbd_in_if.sv
sv/gbd_out_if.sv
sv/gbd_front.sv
sv/gbd_sqrt.sv
sv/gbd_mul.sv
sv/gbd_div.sv
sv/two_body_gravity_derivative_core.sv
sv/gbd_chk.sv
sim/tb_two_body_gravity_derivative_core.sv
